// ===== hw/rtl/sxfr_pkg.sv =====
package sxfr_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int POS_W       = 5;
   localparam int CSR_INDEX_W = 2;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LEN_W-1:0]  len_type;

   localparam byte_type FIRST_SYNC_RESET  = 8'h06;
   localparam byte_type SECOND_SYNC_RESET = 8'h85;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SYNC  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_SYNC = 2'd1;

   typedef enum logic [2:0] {
      ST_SYNC1,
      ST_SYNC2,
      ST_LENGTH,
      ST_PAYLOAD,
      ST_CHECK,
      ST_REPLAY
   } state_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA     = 2'd0,
      KIND_BADSUM   = 2'd1,
      KIND_OVERSIZE = 2'd2
   } kind_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      byte_type wr_data;
      addr_type rd_addr;
   } mem_req_type;

endpackage

// ===== hw/rtl/sxfr_if.sv =====
interface sxfr_req_if;
   logic                   valid;
   logic                   ready;
   sxfr_pkg::byte_type     rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sxfr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sxfr_pkg::KIND_W-1:0] kind;
   sxfr_pkg::byte_type          data;
   logic [sxfr_pkg::POS_W-1:0]  position;
   logic                        last;

   modport source (output valid, output kind, output data, output position, output last,
                   input ready);
   modport sink (input valid, input kind, input data, input position, input last,
                 output ready);
endinterface

interface sxfr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sxfr_pkg::CSR_INDEX_W-1:0] index;
   sxfr_pkg::byte_type               wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/sxfr_store.sv =====
module sxfr_store (
   input  logic                  clock,
   input  sxfr_pkg::mem_req_type mem_req,
   output sxfr_pkg::byte_type    rd_data
);

   sxfr_pkg::byte_type mem_ff [sxfr_pkg::MAX_PAYLOAD];
   sxfr_pkg::byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sxfr_ctrl.sv =====
module sxfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   sxfr_req_if.sink              req,
   sxfr_rsp_if.source            rsp,
   sxfr_csr_if.sink              csr,
   output sxfr_pkg::mem_req_type mem_req,
   input  sxfr_pkg::byte_type    rd_data
);

   sxfr_pkg::state_type            state_ff, state_in;
   sxfr_pkg::byte_type             first_sync_ff, second_sync_ff;
   sxfr_pkg::len_type              len_ff, len_in;
   sxfr_pkg::len_type              count_ff, count_in;
   sxfr_pkg::byte_type             xor_ff, xor_in;
   sxfr_pkg::addr_type             idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sxfr_pkg::KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   sxfr_pkg::byte_type             rsp_data_ff, rsp_data_in;
   logic [sxfr_pkg::POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           out_free;
   logic                           accept;
   logic                           is_last;
   sxfr_pkg::len_type              count_inc;
   sxfr_pkg::len_type              idx_inc;
   sxfr_pkg::byte_type             b;

   assign b         = req.rx_byte;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = out_free && (state_ff != sxfr_pkg::ST_REPLAY);
   assign accept    = req.valid && req.ready;
   assign count_inc = count_ff + sxfr_pkg::LEN_W'(1);
   assign idx_inc   = sxfr_pkg::LEN_W'(idx_ff) + sxfr_pkg::LEN_W'(1);
   assign is_last   = (idx_inc == len_ff);
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sxfr_pkg::ST_SYNC1;
         first_sync_ff  <= sxfr_pkg::FIRST_SYNC_RESET;
         second_sync_ff <= sxfr_pkg::SECOND_SYNC_RESET;
         len_ff         <= '0;
         count_ff       <= '0;
         xor_ff         <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.index == sxfr_pkg::CSR_FIRST_SYNC) begin
            first_sync_ff <= csr.wdata;
         end
         if (csr.valid && csr.index == sxfr_pkg::CSR_SECOND_SYNC) begin
            second_sync_ff <= csr.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      len_in          = len_ff;
      count_in        = count_ff;
      xor_in          = xor_ff;
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_pos_in      = rsp_pos_ff;
      rsp_last_in     = rsp_last_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = count_ff[sxfr_pkg::ADDR_W-1:0];
      mem_req.wr_data = b;
      mem_req.rd_addr = idx_ff;

      unique case (state_ff)
         sxfr_pkg::ST_SYNC1: begin
            if (accept) begin
               state_in = (b == first_sync_ff) ? sxfr_pkg::ST_SYNC2 : sxfr_pkg::ST_SYNC1;
            end
         end
         sxfr_pkg::ST_SYNC2: begin
            if (accept) begin
               state_in = (b == second_sync_ff) ? sxfr_pkg::ST_LENGTH : sxfr_pkg::ST_SYNC1;
            end
         end
         sxfr_pkg::ST_LENGTH: begin
            if (accept) begin
               if (b == '0) begin
                  state_in = sxfr_pkg::ST_SYNC1;
               end else if (b > sxfr_pkg::BYTE_W'(sxfr_pkg::MAX_PAYLOAD)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = sxfr_pkg::KIND_OVERSIZE;
                  rsp_data_in  = '0;
                  rsp_pos_in   = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = sxfr_pkg::ST_SYNC1;
               end else begin
                  len_in   = b[sxfr_pkg::LEN_W-1:0];
                  count_in = '0;
                  xor_in   = b;
                  state_in = sxfr_pkg::ST_PAYLOAD;
               end
            end
         end
         sxfr_pkg::ST_PAYLOAD: begin
            if (accept) begin
               mem_req.wr_en = (count_ff < sxfr_pkg::LEN_W'(sxfr_pkg::MAX_PAYLOAD));
               xor_in        = xor_ff ^ b;
               count_in      = count_inc;
               if (count_inc >= len_ff) begin
                  state_in = sxfr_pkg::ST_CHECK;
               end
            end
         end
         sxfr_pkg::ST_CHECK: begin
            if (accept) begin
               count_in = '0;
               if (b == xor_ff) begin
                  idx_in          = '0;
                  mem_req.rd_addr = '0;
                  state_in        = sxfr_pkg::ST_REPLAY;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = sxfr_pkg::KIND_BADSUM;
                  rsp_data_in  = '0;
                  rsp_pos_in   = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = sxfr_pkg::ST_SYNC1;
               end
            end
         end
         sxfr_pkg::ST_REPLAY: begin
            // The read for the current entry was issued earlier and is registered in the store; the
            // next entry is fetched as the current one moves into the output register.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = sxfr_pkg::KIND_DATA;
               rsp_data_in  = rd_data;
               rsp_pos_in   = idx_ff;
               rsp_last_in  = is_last;
               if (is_last) begin
                  state_in = sxfr_pkg::ST_SYNC1;
               end else begin
                  idx_in          = idx_inc[sxfr_pkg::ADDR_W-1:0];
                  mem_req.rd_addr = idx_inc[sxfr_pkg::ADDR_W-1:0];
               end
            end
         end
         default: begin
            state_in = sxfr_pkg::ST_SYNC1;
         end
      endcase
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_kind_ff;
   assign rsp.data     = rsp_data_ff;
   assign rsp.position = rsp_pos_ff;
   assign rsp.last     = rsp_last_ff;

endmodule

// ===== hw/rtl/sync_length_xor_frame_receiver.sv =====
// Takes one byte per cycle while hunting, reading header, storing payload or checking, unless stalled.
// An error item appears in the cycle after the length or checksum byte that causes it.
// A good frame of N bytes is replayed from payload memory via the store and output registers,
// one item per cycle unless one is held off; no input is taken until the last one is loaded.
// Each cycle that the receiver holds off a waiting item stalls both the input and the replay.
// Reset clears the frame state and output valid and restores sync bytes 0x06 and 0x85.
module sync_length_xor_frame_receiver (
   input logic        clock,
   input logic        reset,
   sxfr_req_if.sink   req_ch,
   sxfr_rsp_if.source rsp_ch,
   sxfr_csr_if.sink   csr_ch
);

   sxfr_pkg::mem_req_type mem_req;
   sxfr_pkg::byte_type    rd_data;

   sxfr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .csr     (csr_ch),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   sxfr_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sxfr_pkg::*;

   typedef struct packed {
      kind_type         kind;
      byte_type         data;
      logic [POS_W-1:0] position;
      logic             last;
   } rx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sxfr_req_if req_if ();
   sxfr_rsp_if rsp_if ();
   sxfr_csr_if csr_if ();

   sync_length_xor_frame_receiver DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #6 clock = ~clock;

   byte_type      tx_bytes[$];
   rx_result_type due_results[$];
   int unsigned   mismatches = 0;
   int unsigned   accepted_bytes = 0;
   logic          req_took = 1'b0;
   logic          rsp_hold = 1'b0;
   int unsigned   req_gap = 0;
   int unsigned   req_quiet = 0;
   int unsigned   rsp_stall = 0;
   int unsigned   rsp_quiet = 0;

   byte_type  first_sync = FIRST_SYNC_RESET;
   byte_type  second_sync = SECOND_SYNC_RESET;
   state_type rx_state = ST_SYNC1;
   len_type   frame_len = '0;
   len_type   byte_cnt = '0;
   byte_type  frame_sum = '0;
   byte_type  payload[MAX_PAYLOAD];

   task automatic report_mismatch(string what);
      $display("%0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic int unsigned idle_len(inout int unsigned quiet);
      int unsigned r;
      if (quiet != 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic void expect_result(kind_type kind, byte_type data, int unsigned pos,
                                         logic last);
      rx_result_type r;
      r.kind = kind;
      r.data = data;
      r.position = pos[POS_W-1:0];
      r.last = last;
      due_results.push_back(r);
   endfunction

   // Advances the frame state by one received byte and queues the results it causes.
   function automatic void deframe_byte(byte_type b);
      case (rx_state)
         ST_SYNC2: rx_state = (b == second_sync) ? ST_LENGTH : ST_SYNC1;
         ST_LENGTH: begin
            if (b == 0) begin
               rx_state = ST_SYNC1;
            end else if (b > MAX_PAYLOAD) begin
               expect_result(KIND_OVERSIZE, '0, 0, 1'b1);
               rx_state = ST_SYNC1;
            end else begin
               frame_len = b[LEN_W-1:0];
               byte_cnt = '0;
               frame_sum = b;
               rx_state = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            if (byte_cnt < MAX_PAYLOAD) payload[byte_cnt[ADDR_W-1:0]] = b;
            frame_sum ^= b;
            byte_cnt = byte_cnt + 1'b1;
            if (byte_cnt >= frame_len) rx_state = ST_CHECK;
         end
         ST_CHECK: begin
            if (b == frame_sum) begin
               for (int i = 0; i < frame_len && i < MAX_PAYLOAD; i++) begin
                  expect_result(KIND_DATA, payload[i], i, (i + 1 == frame_len));
               end
            end else begin
               expect_result(KIND_BADSUM, '0, 0, 1'b1);
            end
            byte_cnt = '0;
            rx_state = ST_SYNC1;
         end
         default: rx_state = (b == first_sync) ? ST_SYNC2 : ST_SYNC1;
      endcase
   endfunction

   function automatic void add_frame(int unsigned len, bit bad_sum);
      byte_type sum;
      byte_type b;
      sum = len[7:0];
      tx_bytes.push_back(first_sync);
      tx_bytes.push_back(second_sync);
      tx_bytes.push_back(len[7:0]);
      repeat (len) begin
         b = $urandom_range(0, 255);
         sum ^= b;
         tx_bytes.push_back(b);
      end
      if (bad_sum) sum ^= byte_type'($urandom_range(1, 255));
      tx_bytes.push_back(sum);
   endfunction

   // Mostly well-formed frames, with broken headers, bad checksums and line noise mixed in.
   function automatic void add_traffic(int unsigned count);
      int unsigned start;
      int unsigned pick;
      int unsigned r;
      int unsigned len;
      start = tx_bytes.size();
      while (tx_bytes.size() - start < count) begin
         pick = $urandom_range(0, 99);
         r = $urandom_range(0, 19);
         len = (r == 0) ? MAX_PAYLOAD : (r < 4) ? $urandom_range(7, 31) : $urandom_range(1, 6);
         if (pick < 60) begin
            add_frame(len, 1'b0);
         end else if (pick < 70) begin
            add_frame(len, 1'b1);
         end else if (pick < 78) begin
            tx_bytes.push_back(first_sync);
            tx_bytes.push_back(second_sync);
            tx_bytes.push_back(byte_type'($urandom_range(MAX_PAYLOAD + 1, 255)));
         end else if (pick < 84) begin
            tx_bytes.push_back(first_sync);
            tx_bytes.push_back(second_sync);
            tx_bytes.push_back(8'h00);
         end else if (pick < 90) begin
            tx_bytes.push_back(first_sync);
            tx_bytes.push_back(second_sync ^ byte_type'($urandom_range(1, 255)));
         end else begin
            repeat ($urandom_range(1, 3)) tx_bytes.push_back(byte_type'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] reg_index, byte_type value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= reg_index;
      csr_if.wdata <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (reg_index == CSR_FIRST_SYNC) first_sync = value;
      else second_sync = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (tx_bytes.size() != 0 || req_if.valid || due_results.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   always @(negedge clock) begin : byte_driver
      if (!reset && (!req_if.valid || req_took)) begin
         if (req_gap != 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (tx_bytes.size() != 0) begin
            req_if.rx_byte <= tx_bytes.pop_front();
            req_if.valid <= 1'b1;
            req_gap = idle_len(req_quiet);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : ready_driver
      if (reset || rsp_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_stall = idle_len(rsp_quiet);
      end
   end

   always @(posedge clock) begin : result_monitor
      rx_result_type want;
      req_took <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("unexpected item kind %0d data %h position %0d last %b",
                                         rsp_if.kind, rsp_if.data, rsp_if.position,
                                         rsp_if.last));
            end else begin
               want = due_results.pop_front();
               if (rsp_if.kind !== want.kind || rsp_if.data !== want.data ||
                   rsp_if.position !== want.position || rsp_if.last !== want.last) begin
                  report_mismatch($sformatf("got %0d/%h/%0d/%b, wanted %0d/%h/%0d/%b",
                                            rsp_if.kind, rsp_if.data, rsp_if.position,
                                            rsp_if.last, want.kind, want.data,
                                            want.position, want.last));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            deframe_byte(req_if.rx_byte);
            accepted_bytes <= accepted_bytes + 1;
         end
      end
   end

   // The receiver stops taking items long enough for the block to back up into its input.
   initial begin : long_hold
      wait (accepted_bytes >= 60);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (150) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      byte_type same_sync;
      req_if.valid = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_FIRST_SYNC;
      csr_if.wdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      tx_bytes = '{
         FIRST_SYNC_RESET, SECOND_SYNC_RESET, 8'h01, 8'h00, 8'h01,
         FIRST_SYNC_RESET, FIRST_SYNC_RESET, SECOND_SYNC_RESET,
         FIRST_SYNC_RESET, SECOND_SYNC_RESET, 8'h00,
         FIRST_SYNC_RESET, SECOND_SYNC_RESET, 8'h21,
         FIRST_SYNC_RESET, SECOND_SYNC_RESET, 8'hFF,
         FIRST_SYNC_RESET, SECOND_SYNC_RESET, 8'h02, 8'hFF, 8'h00, 8'h00,
         FIRST_SYNC_RESET, SECOND_SYNC_RESET, 8'h01, 8'hFF, 8'hFE
      };
      wait_idle();

      write_reg(CSR_FIRST_SYNC, 8'h00);
      write_reg(CSR_SECOND_SYNC, 8'hFF);
      add_frame(MAX_PAYLOAD, 1'b0);
      add_traffic(25);
      wait_idle();

      write_reg(CSR_FIRST_SYNC, 8'hFF);
      write_reg(CSR_SECOND_SYNC, 8'h00);
      add_traffic(25);
      wait_idle();

      write_reg(CSR_FIRST_SYNC, byte_type'($urandom_range(0, 255)));
      write_reg(CSR_SECOND_SYNC, byte_type'($urandom_range(0, 255)));
      add_traffic(25);
      wait_idle();

      same_sync = $urandom_range(0, 255);
      write_reg(CSR_FIRST_SYNC, same_sync);
      write_reg(CSR_SECOND_SYNC, same_sync);
      add_traffic(25);
      wait_idle();

      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sxfr_pkg.sv
hw/rtl/sxfr_if.sv
hw/rtl/sxfr_store.sv
hw/rtl/sxfr_ctrl.sv
hw/rtl/sync_length_xor_frame_receiver.sv
bench/tb.sv
